@@ hdl/e2q_pkg.sv @@
// Shared constants and tables for the Euler-angle to quaternion converter.
package e2q_pkg;

   // Default step count and result width.
   localparam int DefCordicSteps = 16;
   localparam int DefOutWidth    = 16;

   // Length of the arctangent table, and so the most CORDIC steps that are ever run.
   localparam int TableLen = 24;

   // Angle and datapath widths.
   localparam int AngleWidth = 17;
   localparam int RedWidth   = 16;
   localparam int DataWidth  = 32;

   // Half-angle units of 1/256 degree.
   localparam logic signed [17:0] FullTurn    = 18'sd92160;
   localparam logic signed [17:0] HalfTurn    = 18'sd46080;
   localparam logic signed [17:0] QuarterTurn = 18'sd23040;

   // Radians per half-angle unit, scaled so that the product lands in Q30 after a 16-bit shift.
   localparam logic [63:0] PiQ60      = 64'h3243F6A8885A308D;
   localparam logic [63:0] RadPerUnit64 = (PiQ60 >> 14) / 64'd46080;
   localparam logic [32:0] RadPerUnit = RadPerUnit64[32:0];

   // CORDIC gain compensation, Q30.
   localparam logic signed [DataWidth-1:0] CordicK = 32'sd652032874;

   // Arctangent of 2^-i in Q30, truncated.
   function automatic logic signed [DataWidth-1:0] atan_q30(input int idx);
      logic signed [DataWidth-1:0] v;
      case (idx)
         0:  v = 32'sh3243F6A8;
         1:  v = 32'sh1DAC6705;
         2:  v = 32'sh0FADBAFC;
         3:  v = 32'sh07F56EA6;
         4:  v = 32'sh03FEAB76;
         5:  v = 32'sh01FFD55B;
         6:  v = 32'sh00FFFAAA;
         7:  v = 32'sh007FFF55;
         8:  v = 32'sh003FFFEA;
         9:  v = 32'sh001FFFFD;
         10: v = 32'sh000FFFFF;
         11: v = 32'sh0007FFFF;
         12: v = 32'sh0003FFFF;
         13: v = 32'sh0001FFFF;
         14: v = 32'sh0000FFFF;
         15: v = 32'sh00007FFF;
         16: v = 32'sh00003FFF;
         17: v = 32'sh00001FFF;
         18: v = 32'sh00000FFF;
         19: v = 32'sh000007FF;
         20: v = 32'sh000003FF;
         21: v = 32'sh000001FF;
         22: v = 32'sh000000FF;
         23: v = 32'sh0000007F;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Pipeline depth of one lane and of the merging stage.
   localparam int MergeLat = 3;
   function automatic int lane_lat(input int steps);
      return steps + 3;
   endfunction

endpackage

@@ hdl/e2q_lane.sv @@
// One lane: reduces an angle and finds the half-angle cosine and sine by a pipelined CORDIC.
module e2q_lane #(
   parameter int STEPS = 16
) (
   input  logic                                     clock,
   input  logic                                     advance,
   input  logic signed [e2q_pkg::AngleWidth-1:0]    angle,
   output logic signed [e2q_pkg::DataWidth-1:0]     cos_out,
   output logic signed [e2q_pkg::DataWidth-1:0]     sin_out
);
   import e2q_pkg::*;

   logic signed [17:0]          wrap_in;
   logic signed [17:0]          fold_in;
   logic                        neg_in;
   logic signed [RedWidth-1:0]  red_ff;
   logic                        rneg_ff;
   logic signed [49:0]          prod_in;
   logic signed [49:0]          prod_rnd;
   logic signed [DataWidth-1:0] x_ff [0:STEPS];
   logic signed [DataWidth-1:0] y_ff [0:STEPS];
   logic signed [DataWidth-1:0] z_ff [0:STEPS];
   logic                        neg_ff [0:STEPS];
   logic signed [DataWidth-1:0] cos_ff;
   logic signed [DataWidth-1:0] sin_ff;

   // Wrap into one full turn, then fold into a quarter turn either side of zero.
   always_comb begin
      wrap_in = 18'(angle);
      if (wrap_in > HalfTurn) begin
         wrap_in = wrap_in - FullTurn;
      end else if (wrap_in <= -HalfTurn) begin
         wrap_in = wrap_in + FullTurn;
      end
      fold_in = wrap_in;
      neg_in  = 1'b0;
      if (wrap_in > QuarterTurn) begin
         fold_in = wrap_in - HalfTurn;
         neg_in  = 1'b1;
      end else if (wrap_in < -QuarterTurn) begin
         fold_in = wrap_in + HalfTurn;
         neg_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         red_ff  <= fold_in[RedWidth-1:0];
         rneg_ff <= neg_in;
      end
   end

   // Scale to radians in Q30 with rounding.
   assign prod_in  = 50'(red_ff) * 50'($signed({1'b0, RadPerUnit}));
   assign prod_rnd = (prod_in + 50'sd32768) >>> 16;

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]   <= CordicK;
         y_ff[0]   <= '0;
         z_ff[0]   <= prod_rnd[DataWidth-1:0];
         neg_ff[0] <= rneg_ff;
      end
   end

   // One rotation per stage; the sign of the residual angle picks the direction.
   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic signed [DataWidth-1:0] dx;
      logic signed [DataWidth-1:0] dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (advance) begin
            if (!z_ff[i][DataWidth-1]) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - atan_q30(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + atan_q30(i);
            end
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   // Undo the fold by negating both results.
   always_ff @(posedge clock) begin
      if (advance) begin
         cos_ff <= neg_ff[STEPS] ? -x_ff[STEPS] : x_ff[STEPS];
         sin_ff <= neg_ff[STEPS] ? -y_ff[STEPS] : y_ff[STEPS];
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

@@ hdl/e2q_merge.sv @@
// Merging stage: forms the four quaternion components from the three lanes' results.
module e2q_merge #(
   parameter int OUT_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 advance,
   input  logic signed [e2q_pkg::DataWidth-1:0] cr,
   input  logic signed [e2q_pkg::DataWidth-1:0] sr,
   input  logic signed [e2q_pkg::DataWidth-1:0] cp,
   input  logic signed [e2q_pkg::DataWidth-1:0] sp,
   input  logic signed [e2q_pkg::DataWidth-1:0] cy,
   input  logic signed [e2q_pkg::DataWidth-1:0] sy,
   output logic signed [OUT_WIDTH-1:0]          comp_w,
   output logic signed [OUT_WIDTH-1:0]          comp_x,
   output logic signed [OUT_WIDTH-1:0]          comp_y,
   output logic signed [OUT_WIDTH-1:0]          comp_z
);
   import e2q_pkg::*;

   localparam int Sh = 31 - OUT_WIDTH;
   localparam logic signed [63:0] Lim = (64'sd1 <<< (OUT_WIDTH - 1)) - 64'sd1;

   // Q30 product rounded back to Q30.
   function automatic logic signed [DataWidth-1:0] mul30(
      input logic signed [DataWidth-1:0] a,
      input logic signed [DataWidth-1:0] b
   );
      logic signed [63:0] p;
      p = (64'(a) * 64'(b) + 64'sd536870912) >>> 30;
      return p[DataWidth-1:0];
   endfunction

   // Rounding to the output format with saturation.
   function automatic logic signed [OUT_WIDTH-1:0] to_out(input logic signed [DataWidth:0] s);
      logic signed [63:0] v;
      v = 64'(s);
      if (Sh > 0) begin
         v = (v + (64'sd1 <<< ((Sh > 0 ? Sh : 1) - 1))) >>> (Sh > 0 ? Sh : 0);
      end else if (Sh < 0) begin
         v = v <<< (Sh < 0 ? -Sh : 0);
      end
      if (v > Lim) begin
         v = Lim;
      end
      if (v < -Lim) begin
         v = -Lim;
      end
      return v[OUT_WIDTH-1:0];
   endfunction

   logic signed [DataWidth-1:0] cycp_ff, sysp_ff, sycp_ff, cysp_ff;
   logic signed [DataWidth-1:0] cr_ff, sr_ff;
   logic signed [DataWidth-1:0] t_ff [0:7];
   logic signed [OUT_WIDTH-1:0] w_ff, x_ff, y_ff, z_ff;

   // Yaw and pitch pairs first; roll waits one stage alongside.
   always_ff @(posedge clock) begin
      if (advance) begin
         cycp_ff <= mul30(cy, cp);
         sysp_ff <= mul30(sy, sp);
         sycp_ff <= mul30(sy, cp);
         cysp_ff <= mul30(cy, sp);
         cr_ff   <= cr;
         sr_ff   <= sr;
      end
   end

   // Third factor of each triple product.
   always_ff @(posedge clock) begin
      if (advance) begin
         t_ff[0] <= mul30(cycp_ff, cr_ff);
         t_ff[1] <= mul30(sysp_ff, sr_ff);
         t_ff[2] <= mul30(cycp_ff, sr_ff);
         t_ff[3] <= mul30(sysp_ff, cr_ff);
         t_ff[4] <= mul30(sycp_ff, sr_ff);
         t_ff[5] <= mul30(cysp_ff, cr_ff);
         t_ff[6] <= mul30(sycp_ff, cr_ff);
         t_ff[7] <= mul30(cysp_ff, sr_ff);
      end
   end

   // Sums, rounding and saturation into the output register.
   always_ff @(posedge clock) begin
      if (advance) begin
         w_ff <= to_out(33'(t_ff[0]) + 33'(t_ff[1]));
         x_ff <= to_out(33'(t_ff[2]) - 33'(t_ff[3]));
         y_ff <= to_out(33'(t_ff[4]) + 33'(t_ff[5]));
         z_ff <= to_out(33'(t_ff[6]) - 33'(t_ff[7]));
      end
   end

   assign comp_w = w_ff;
   assign comp_x = x_ff;
   assign comp_y = y_ff;
   assign comp_z = z_ff;

endmodule

@@ hdl/euler_to_quaternion.sv @@
// Throughput: one request per cycle while no result is held at the output under stall; three
// CORDIC lanes, one per angle, each take a new angle every cycle on the same terms, and the
// merging stage's twelve multipliers and sums are pipelined over three stages.
// The whole pipeline holds only while a result waits at the output under stall.
// Reset (synchronous, active high) clears the valid bits of every stage; no other state is reset.
module euler_to_quaternion #(
   parameter int CORDIC_STEPS = e2q_pkg::DefCordicSteps,
   parameter int OUT_WIDTH    = e2q_pkg::DefOutWidth
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [e2q_pkg::AngleWidth-1:0] req_roll_angle,
   input  logic signed [e2q_pkg::AngleWidth-1:0] req_pitch_angle,
   input  logic signed [e2q_pkg::AngleWidth-1:0] req_yaw_angle,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [OUT_WIDTH-1:0]           rsp_comp_w,
   output logic signed [OUT_WIDTH-1:0]           rsp_comp_x,
   output logic signed [OUT_WIDTH-1:0]           rsp_comp_y,
   output logic signed [OUT_WIDTH-1:0]           rsp_comp_z
);
   import e2q_pkg::*;

   localparam int Steps = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;
   localparam int Lat   = lane_lat(Steps) + MergeLat;

   logic                        advance;
   logic [Lat-1:0]              vld_ff;
   logic [Lat-1:0]              vld_in;
   logic signed [DataWidth-1:0] cr, sr, cp, sp, cy, sy;

   // Everything moves unless a result is held at the output.
   assign advance   = !(vld_ff[Lat-1] && rsp_stall);
   assign req_stall = !advance;

   // Valid bit of each pipeline stage.
   assign vld_in = advance ? {vld_ff[Lat-2:0], req_valid} : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // One lane for each angle.
   e2q_lane #(.STEPS(Steps)) u_roll (
      .clock(clock), .advance(advance), .angle(req_roll_angle), .cos_out(cr), .sin_out(sr)
   );
   e2q_lane #(.STEPS(Steps)) u_pitch (
      .clock(clock), .advance(advance), .angle(req_pitch_angle), .cos_out(cp), .sin_out(sp)
   );
   e2q_lane #(.STEPS(Steps)) u_yaw (
      .clock(clock), .advance(advance), .angle(req_yaw_angle), .cos_out(cy), .sin_out(sy)
   );

   // Triple products and output register.
   e2q_merge #(.OUT_WIDTH(OUT_WIDTH)) u_merge (
      .clock(clock), .advance(advance),
      .cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
      .comp_w(rsp_comp_w), .comp_x(rsp_comp_x), .comp_y(rsp_comp_y), .comp_z(rsp_comp_z)
   );

   assign rsp_valid = vld_ff[Lat-1];

endmodule

@@ hdl/e2q_checker.sv @@
// Port-level checks for the Euler-angle to quaternion converter, bound to the top level.
module e2q_checker #(
   parameter int OUT_WIDTH = e2q_pkg::DefOutWidth
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic signed [OUT_WIDTH-1:0] rsp_comp_w,
   input logic signed [OUT_WIDTH-1:0] rsp_comp_x,
   input logic signed [OUT_WIDTH-1:0] rsp_comp_y,
   input logic signed [OUT_WIDTH-1:0] rsp_comp_z
);

   localparam logic signed [OUT_WIDTH-1:0] MostNeg = {1'b1, {(OUT_WIDTH-1){1'b0}}};

   // A result held under stall stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // Requests are held back only while a result is held at the output.
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without an output stall");

   // No result straight after reset.
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered after reset");

   // Saturation never gives the most negative code.
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_comp_w != MostNeg && rsp_comp_x != MostNeg &&
                    rsp_comp_y != MostNeg && rsp_comp_z != MostNeg)
      else $error("component outside the saturated range");

endmodule

bind euler_to_quaternion e2q_checker #(.OUT_WIDTH(OUT_WIDTH)) u_e2q_checker (
   .clock(clock), .reset(reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_comp_w(rsp_comp_w), .rsp_comp_x(rsp_comp_x),
   .rsp_comp_y(rsp_comp_y), .rsp_comp_z(rsp_comp_z)
);

@@ tb/euler_to_quaternion_test.sv @@
// Self-checking testbench for the Euler-angle to quaternion converter.
module euler_to_quaternion_test;
   import e2q_pkg::*;

   localparam int Steps     = DefCordicSteps;
   localparam int OutW      = DefOutWidth;
   localparam int Latency   = (Steps < TableLen ? Steps : TableLen) + 6;
   localparam int NumRandom = 1000;
   localparam int IdleLimit = 2000;
   localparam int DirLen    = 22;

   typedef logic signed [AngleWidth-1:0] angle_type;
   typedef logic signed [OutW-1:0] comp_type;

   typedef struct {
      comp_type w;
      comp_type x;
      comp_type y;
      comp_type z;
   } quat_type;

   typedef struct {
      angle_type roll;
      angle_type pitch;
      angle_type yaw;
      bit        known;
      quat_type  q;
   } dir_row_type;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_stall;
   angle_type req_roll_angle;
   angle_type req_pitch_angle;
   angle_type req_yaw_angle;
   logic      rsp_valid;
   logic      rsp_stall;
   comp_type  rsp_comp_w;
   comp_type  rsp_comp_x;
   comp_type  rsp_comp_y;
   comp_type  rsp_comp_z;

   quat_type    pending_quats[$];
   int          failures;
   int          idle_cycles;
   bit          quiet_phase;
   bit          timed_out;
   dir_row_type dir_rows[DirLen];

   euler_to_quaternion #(.CORDIC_STEPS(Steps), .OUT_WIDTH(OutW)) dut (.*);

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Floor division by a power of two.
   function automatic longint fl_shift(longint v, int s);
      return v >>> s;
   endfunction

   // Half-angle cosine and sine in Q30 for one raw angle.
   function automatic void half_cos_sin(angle_type raw, output longint c, output longint s);
      longint r, x, y, z, dx, dy, rad;
      bit neg;
      int n;
      rad = longint'((PiQ60 >> 14) / 64'd46080);
      r = longint'(raw);
      r = ((r % 92160) + 92160) % 92160;
      if (r > 46080) r -= 92160;
      neg = 1'b0;
      if (r > 23040) begin
         r -= 46080;
         neg = 1'b1;
      end else if (r < -23040) begin
         r += 46080;
         neg = 1'b1;
      end
      z = fl_shift(r * rad + (64'sd1 <<< 15), 16);
      x = longint'(CordicK);
      y = 0;
      n = Steps < TableLen ? Steps : TableLen;
      for (int i = 0; i < n; i++) begin
         dx = fl_shift(y, i);
         dy = fl_shift(x, i);
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= longint'(atan_q30(i));
         end else begin
            x += dx;
            y -= dy;
            z += longint'(atan_q30(i));
         end
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
   endfunction

   function automatic longint q30_mul(longint a, longint b);
      return fl_shift(a * b + (64'sd1 <<< 29), 30);
   endfunction

   function automatic longint q30_triple(longint a, longint b, longint c);
      return q30_mul(q30_mul(a, b), c);
   endfunction

   // Round a Q30 sum to the output format and saturate.
   function automatic comp_type to_comp(longint v);
      longint lim;
      int sh;
      lim = (64'sd1 <<< (OutW - 1)) - 1;
      sh = 31 - OutW;
      if (sh > 0) v = fl_shift(v + (64'sd1 <<< (sh - 1)), sh);
      else if (sh < 0) v = v <<< (-sh);
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return comp_type'(v);
   endfunction

   // Expected quaternion for one angle triple.
   function automatic quat_type zyx_quat(angle_type roll, angle_type pitch, angle_type yaw);
      longint cr, sr, cp, sp, cy, sy;
      quat_type q;
      half_cos_sin(roll, cr, sr);
      half_cos_sin(pitch, cp, sp);
      half_cos_sin(yaw, cy, sy);
      q.w = to_comp(q30_triple(cy, cp, cr) + q30_triple(sy, sp, sr));
      q.x = to_comp(q30_triple(cy, cp, sr) - q30_triple(sy, sp, cr));
      q.y = to_comp(q30_triple(sy, cp, sr) + q30_triple(cy, sp, cr));
      q.z = to_comp(q30_triple(sy, cp, cr) - q30_triple(cy, sp, sr));
      return q;
   endfunction

   function automatic dir_row_type mk_row(int r, int p, int y);
      dir_row_type d;
      d.roll = angle_type'(r);
      d.pitch = angle_type'(p);
      d.yaw = angle_type'(y);
      d.known = 1'b0;
      d.q = '{default: '0};
      return d;
   endfunction

   // Random angle: mostly in range, sometimes any pattern or a boundary.
   function automatic angle_type rand_angle();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 7) return angle_type'($urandom_range(0, 92160) - 46080);
      if (sel < 9) return angle_type'($urandom);
      case ($urandom_range(0, 5))
         0: return angle_type'(23040);
         1: return angle_type'(-23040);
         2: return angle_type'(46080);
         3: return angle_type'(-46080);
         4: return angle_type'(11520);
         default: return angle_type'(0);
      endcase
   endfunction

   // Present one request and hold it until accepted.
   task automatic send_request(angle_type r, angle_type p, angle_type y);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_roll_angle  <= r;
      req_pitch_angle <= p;
      req_yaw_angle   <= y;
      pending_quats.push_back(zyx_quat(r, p, y));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Receiver stall in random bursts.
   initial begin
      int burst;
      rsp_stall = 1'b0;
      burst = 0;
      forever begin
         @(posedge clock);
         if (burst > 0) burst--;
         else if (!quiet_phase && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 4);
         rsp_stall <= (burst > 0);
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      quat_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_quats.size() == 0) begin
            $display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d", $time,
                     rsp_comp_w, rsp_comp_x, rsp_comp_y, rsp_comp_z);
            failures++;
         end else begin
            e = pending_quats.pop_front();
            if (rsp_comp_w !== e.w || rsp_comp_x !== e.x ||
                rsp_comp_y !== e.y || rsp_comp_z !== e.z) begin
               $display("%0t: mismatch expected w=%0d x=%0d y=%0d z=%0d %s",
                        $time, e.w, e.x, e.y, e.z, "actual");
               $display("%0t:          actual w=%0d x=%0d y=%0d z=%0d",
                        $time, rsp_comp_w, rsp_comp_x, rsp_comp_y, rsp_comp_z);
               failures++;
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on either side.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Stimulus.
   initial begin
      angle_type r, p, y;
      failures        = 0;
      idle_cycles     = 0;
      quiet_phase     = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_roll_angle  = '0;
      req_pitch_angle = '0;
      req_yaw_angle   = '0;

      // Directed rows. For zero angles the cosines round up to full scale, and the CORDIC
      // leaves a small negative sine residue that rounds to minus one LSB.
      dir_rows[0] = mk_row(0, 0, 0);
      dir_rows[0].known = 1'b1;
      dir_rows[0].q = '{w: 16'sd32767, x: -16'sd1, y: -16'sd1, z: -16'sd1};
      dir_rows[1]  = mk_row(46080, 46080, 46080);
      dir_rows[2]  = mk_row(-46080, -46080, -46080);
      dir_rows[3]  = mk_row(23040, 0, 0);
      dir_rows[4]  = mk_row(0, 23040, 0);
      dir_rows[5]  = mk_row(0, 0, 23040);
      dir_rows[6]  = mk_row(-23040, -23040, -23040);
      dir_rows[7]  = mk_row(23041, -23041, 23039);
      dir_rows[8]  = mk_row(65535, -65536, 46081);
      dir_rows[9]  = mk_row(-46081, 65535, -65536);
      dir_rows[10] = mk_row(11520, 11520, 11520);
      dir_rows[11] = mk_row(1, -1, 1);
      dir_rows[12] = mk_row(-1, 1, -1);
      dir_rows[13] = mk_row(34560, -34560, 5760);
      dir_rows[14] = mk_row(46079, -46079, 0);
      dir_rows[15] = mk_row(0, 46080, -23040);
      dir_rows[16] = mk_row(43690, -21846, 21845);
      dir_rows[17] = mk_row(-43691, 21846, -21846);
      dir_rows[18] = mk_row(4660, -4661, 22136);
      dir_rows[19] = mk_row(30000, 40000, -45000);
      dir_rows[20] = mk_row(-65536, -65536, -65536);
      dir_rows[21] = mk_row(65535, 65535, 65535);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         send_request(dir_rows[i].roll, dir_rows[i].pitch, dir_rows[i].yaw);
         if (dir_rows[i].known) begin
            pending_quats[pending_quats.size() - 1] = dir_rows[i].q;
         end
      end

      // Random part, with one full drain in the middle.
      for (int n = 0; n < NumRandom; n++) begin
         if (n == NumRandom / 2) begin
            req_valid <= 1'b0;
            while (pending_quats.size() > 0) @(posedge clock);
         end
         if (n == NumRandom - 150) quiet_phase = 1'b1;
         r = rand_angle();
         p = rand_angle();
         y = rand_angle();
         send_request(r, p, y);
      end
      req_valid <= 1'b0;

      timed_out = 1'b0;
      for (int c = 0; c < IdleLimit && pending_quats.size() > 0; c++) @(posedge clock);
      if (pending_quats.size() > 0) timed_out = 1'b1;
      repeat (Latency + 4) @(posedge clock);

      if (failures == 0 && !timed_out) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
